/* hw/rtl/sqru_pkg.sv */
package sqru_pkg;

  // Radicand is a plain 64-bit unsigned integer
  localparam int RADICAND_W = 64;

  // Integer part of the root is always 32 bits wide
  localparam int INT_BITS = 32;

  // Each recurrence step brings down one pair of radicand bits
  localparam int PAIR_W = 2;

endpackage

/* hw/rtl/sqru_ifs.sv */
interface sqru_req_if
  import sqru_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [RADICAND_W-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink (input valid, input radicand, output ready);
endinterface

interface sqru_rsp_if
  import sqru_pkg::*;
  #(parameter int ROOT_W = INT_BITS + 16)
  ();
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] root_value;

  modport source (output valid, output root_value, input ready);
  modport sink (input valid, input root_value, output ready);
endinterface

/* hw/rtl/sqru_stage.sv */
module sqru_stage
  import sqru_pkg::*;
#(
  parameter int ROOT_W = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  valid_in,
  input  logic [ROOT_W+1:0]     rem_in,
  input  logic [ROOT_W-1:0]     root_in,
  input  logic [RADICAND_W-1:0] opnd_in,
  output logic                  valid,
  output logic [ROOT_W+1:0]     rem,
  output logic [ROOT_W-1:0]     root,
  output logic [RADICAND_W-1:0] opnd
);

  logic [ROOT_W+1:0]     rem_sh;
  logic [ROOT_W+1:0]     trial;
  logic [ROOT_W+2:0]     diff;
  logic                  take;
  logic [ROOT_W+1:0]     rem_next;
  logic [ROOT_W-1:0]     root_next;
  logic [RADICAND_W-1:0] opnd_next;

  // Bring down the next bit pair and try a one in this root position
  always_comb begin
    rem_sh    = {rem_in[ROOT_W-1:0], opnd_in[RADICAND_W-1 -: PAIR_W]};
    trial     = {root_in, 2'b01};
    diff      = {1'b0, rem_sh} - {1'b0, trial};
    take      = ~diff[ROOT_W+2];
    rem_next  = take ? diff[ROOT_W+1:0] : rem_sh;
    root_next = {root_in[ROOT_W-2:0], take};
    opnd_next = {opnd_in[RADICAND_W-PAIR_W-1:0], {PAIR_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      root <= root_next;
      opnd <= opnd_next;
    end
  end

endmodule

/* hw/rtl/sqru_outq.sv */
module sqru_outq #(
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* hw/rtl/square_root_unit.sv */
// Fixed-point square root, fully pipelined.
//
// req (sink): valid/ready request channel carrying a 64-bit unsigned radicand.
// rsp (source): valid/ready channel carrying root_value, the square root in
//   unsigned 32.FRACTION_BITS fixed point, truncated toward zero. A zero
//   radicand gives zero; the root always fits, so nothing saturates.
//
// Throughput: one request per cycle, sustained, while rsp is being drained.
// Structure: one pipeline stage per root bit, 32 + FRACTION_BITS stages, as
//   set by the digit recurrence, followed by the output queue.
//
// Reset (rst, synchronous, active high) drops every request in flight and
//   empties the output queue; the block accepts requests in the next cycle.
// Stall: results land in a two-entry output queue. While it has space the
//   whole pipeline advances and req.ready stays high, so a request is still
//   taken while one result waits. Once it fills, the pipeline holds in place
//   and req.ready drops until the receiver takes a result.
module square_root_unit
  import sqru_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  sqru_req_if.sink   req,
  sqru_rsp_if.source rsp
);

  localparam int ROOT_W = INT_BITS + FRACTION_BITS;
  localparam int STAGES = ROOT_W;

  logic                  adv;
  logic                  q_full;

  // Stage outputs; index i is the register after root bit i is decided
  logic                  st_valid [STAGES];
  logic [ROOT_W+1:0]     st_rem   [STAGES];
  logic [ROOT_W-1:0]     st_root  [STAGES];
  logic [RADICAND_W-1:0] st_opnd  [STAGES];

  // Advance the whole pipeline only while the queue has a free slot
  assign adv       = ~q_full;
  assign req.ready = adv;

  // First stage starts from an empty remainder and root
  sqru_stage #(
    .ROOT_W (ROOT_W)
  ) u_stage_first (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .valid_in (req.valid),
    .rem_in   ('0),
    .root_in  ('0),
    .opnd_in  (req.radicand),
    .valid    (st_valid[0]),
    .rem      (st_rem[0]),
    .root     (st_root[0]),
    .opnd     (st_opnd[0])
  );

  // Remaining stages; once the radicand bits run out the shifted operand
  // is zero, which brings down the fraction pairs
  for (genvar i = 1; i < STAGES; i++) begin : g_stage
    sqru_stage #(
      .ROOT_W (ROOT_W)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .valid_in (st_valid[i-1]),
      .rem_in   (st_rem[i-1]),
      .root_in  (st_root[i-1]),
      .opnd_in  (st_opnd[i-1]),
      .valid    (st_valid[i]),
      .rem      (st_rem[i]),
      .root     (st_root[i]),
      .opnd     (st_opnd[i])
    );
  end

  // Queue space is guaranteed whenever the pipeline advances
  sqru_outq #(
    .DATA_W (ROOT_W)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (adv & st_valid[STAGES-1]),
    .push_data (st_root[STAGES-1]),
    .full      (q_full),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp.root_value)
  );

endmodule

/* bench/square_root_unit_tb.sv */
`timescale 1ns / 100ps

module square_root_unit_tb;
  import sqru_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int ROOT_W = INT_BITS + FRAC_BITS;
  // The radicand scaled by 2^(2*FRAC_BITS) is as wide as the square of a root
  localparam int SCALED_W = RADICAND_W + 2 * FRAC_BITS;
  // One stage per root bit plus the output queue, as the block's header gives it
  localparam int LATENCY = 33 + FRAC_BITS;
  localparam int HOLD_CYCLES = 4 * LATENCY;
  localparam int DIRECTED_ROWS = 18;
  localparam int MAX_REPORTS = 10;

  // One row of the directed table: root_typed marks a root read straight off
  // the arithmetic; every other row is left to the predictor.
  typedef struct packed {
    logic [RADICAND_W-1:0] radicand;
    logic                  root_typed;
    logic [ROOT_W-1:0]     root_value;
  } sqrt_row_t;

  // A root still owed by the block, kept with the radicand that caused it
  typedef struct packed {
    logic [RADICAND_W-1:0] radicand;
    logic [ROOT_W-1:0]     root_value;
  } owed_root_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sqru_req_if req_ch ();
  sqru_rsp_if #(.ROOT_W(ROOT_W)) rsp_ch ();

  square_root_unit #(
    .FRACTION_BITS(FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  owed_root_t owed_roots[$];
  int         error_count = 0;
  int         send_idle_max = 0;
  int         take_idle_max = 0;
  bit         hold_requested = 1'b0;

  // Directed requests: zero, the smallest non-zero values, exact squares on
  // both sides of the range, the largest radicand (root must not wrap) and
  // alternating bit patterns so that every radicand bit sees both values.
  sqrt_row_t directed_rows [DIRECTED_ROWS] = '{
    '{64'h0000_0000_0000_0000, 1'b1, 48'h0000_0000_0000},
    '{64'h0000_0000_0000_0001, 1'b1, 48'h0000_0001_0000},
    '{64'h0000_0000_0000_0002, 1'b0, 48'h0},
    '{64'h0000_0000_0000_0003, 1'b0, 48'h0},
    '{64'h0000_0000_0000_0004, 1'b1, 48'h0000_0002_0000},
    '{64'h0000_0000_0001_0000, 1'b1, 48'h0000_0100_0000},
    '{64'h0000_0000_FFFF_FFFF, 1'b0, 48'h0},
    '{64'h0000_0001_0000_0000, 1'b1, 48'h0001_0000_0000},
    '{64'h4000_0000_0000_0000, 1'b1, 48'h8000_0000_0000},
    '{64'h8000_0000_0000_0000, 1'b0, 48'h0},
    '{64'h5555_5555_5555_5555, 1'b0, 48'h0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 48'h0},
    '{64'h0123_4567_89AB_CDEF, 1'b0, 48'h0},
    '{64'hFEDC_BA98_7654_3210, 1'b0, 48'h0},
    '{64'hFFFF_FFFE_0000_0000, 1'b0, 48'h0},
    '{64'hFFFF_FFFE_0000_0001, 1'b1, 48'hFFFF_FFFF_0000},
    '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 48'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF}
  };

  // Truncated fixed-point root: the largest r with r*r <= radicand * 2^(2F),
  // settled one bit at a time from the top.
  function automatic logic [ROOT_W-1:0] fixed_root(input logic [RADICAND_W-1:0] radicand);
    logic [SCALED_W-1:0] scaled;
    logic [ROOT_W-1:0]   acc;
    logic [ROOT_W-1:0]   trial;
    logic [2*ROOT_W-1:0] trial_sq;
    scaled = SCALED_W'(radicand) << (2 * FRAC_BITS);
    acc = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = acc | (ROOT_W'(1) << b);
      trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);
      if (trial_sq <= scaled) begin
        acc = trial;
      end
    end
    return acc;
  endfunction

  // Draw a radicand: often full-range, with weight on small values, exact
  // squares and their neighbours, the top of the range and single-bit edges.
  function automatic logic [RADICAND_W-1:0] draw_radicand();
    logic [RADICAND_W-1:0] base;
    logic [RADICAND_W-1:0] sq;
    int                    k;
    base = {$urandom, $urandom};
    k = $urandom_range(RADICAND_W - 1, 0);
    case ($urandom_range(9, 0))
      4, 5: begin
        return base >> k;
      end
      6, 7: begin
        sq = RADICAND_W'(base[31:0]) * RADICAND_W'(base[31:0]);
        case ($urandom_range(2, 0))
          0: return sq;
          1: return sq - 1;
          default: return sq + 1;
        endcase
      end
      8: begin
        return ~RADICAND_W'($urandom_range(1023, 0));
      end
      9: begin
        return $urandom_range(1, 0) ? (RADICAND_W'(1) << k) : ((RADICAND_W'(1) << k) - 1);
      end
      default: begin
        return base;
      end
    endcase
  endfunction

  task automatic flag_error(input string what);
    if (error_count < MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, what);
    end
    error_count++;
  endtask

  // Offer one request after a random gap and hold it until the block takes it.
  // Valid is only lowered when a gap follows, so a back-to-back request never
  // sees valid dropped and raised in the same step.
  task automatic send_request(input logic [RADICAND_W-1:0] radicand,
                              input logic [ROOT_W-1:0] root_value);
    int gap;
    gap = $urandom_range(send_idle_max, 0);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.radicand <= radicand;
    do @(posedge clk); while (!req_ch.ready);
    owed_roots.push_back('{radicand, root_value});
  endtask

  task automatic wait_drained();
    while (owed_roots.size() != 0) @(posedge clk);
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard limit: far beyond the slowest correct run (every request and every
  // result waiting out the longest gap, plus the hold-off and the pauses).
  initial begin
    #(5_000_000);
    $display("[%0t] run timed out with %0d roots outstanding", $realtime, owed_roots.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: stall at random, or hold off for a long stretch on request,
  // then take one root and compare it with the oldest one owed.
  initial begin : take_roots
    int         stall;
    owed_root_t want;
    while (rst) @(posedge clk);
    forever begin
      if (hold_requested) begin
        // Hold ready low long enough for the pipeline and the queue to fill
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_requested = 1'b0;
      end else begin
        stall = $urandom_range(take_idle_max, 0);
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      if (owed_roots.size() == 0) begin
        flag_error($sformatf("root %h arrived with no request outstanding",
                             rsp_ch.root_value));
      end else begin
        want = owed_roots.pop_front();
        if (rsp_ch.root_value !== want.root_value) begin
          flag_error($sformatf("radicand %h: root expected %h, got %h",
                               want.radicand, want.root_value, rsp_ch.root_value));
        end
      end
    end
  end

  // Request side and run control
  initial begin : run_requests
    logic [RADICAND_W-1:0] radicand;
    sqrt_row_t             row;
    req_ch.valid <= 1'b0;
    req_ch.radicand <= '0;
    rsp_ch.ready <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table with moderate idling on both sides
    send_idle_max = 3;
    take_idle_max = 3;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      send_request(row.radicand,
                   row.root_typed ? row.root_value : fixed_root(row.radicand));
    end

    // Stream flat out: no idling on either side
    send_idle_max = 0;
    take_idle_max = 0;
    repeat (200) begin
      radicand = draw_radicand();
      send_request(radicand, fixed_root(radicand));
    end

    // Pause the sender until every owed root is back
    req_ch.valid <= 1'b0;
    wait_drained();

    // Long receiver hold-off while requests keep coming: fill the block and
    // stall its input
    hold_requested = 1'b1;
    repeat (120) begin
      radicand = draw_radicand();
      send_request(radicand, fixed_root(radicand));
    end
    req_ch.valid <= 1'b0;
    wait_drained();

    // Mixed stretches: each side picks idling or none per block of requests
    repeat (16) begin
      send_idle_max = $urandom_range(1, 0) ? 16 : 0;
      take_idle_max = $urandom_range(1, 0) ? 16 : 0;
      repeat (40) begin
        radicand = draw_radicand();
        send_request(radicand, fixed_root(radicand));
      end
    end
    req_ch.valid <= 1'b0;

    // Drain, then allow a pipeline's worth of cycles for stray results
    take_idle_max = 0;
    wait_drained();
    repeat (LATENCY + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sqru_pkg.sv
hw/rtl/sqru_ifs.sv
hw/rtl/sqru_stage.sv
hw/rtl/sqru_outq.sv
hw/rtl/square_root_unit.sv
bench/square_root_unit_tb.sv
